// ===== design/recent_message_dedup_ring_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the recent message dedup ring
// Clocked concurrent assertions, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef RECENT_MESSAGE_DEDUP_RING_CORE_MACROS_SVH
`define RECENT_MESSAGE_DEDUP_RING_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define RMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included
`define RMD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== design/rmd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared constants and types of the recent message dedup ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmd_pkg;

    // Ring geometry
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Item fields
    localparam int SEQ_W  = 16;
    localparam int HALF_W = 64;
    localparam int V4_W   = 32;

    // Function codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_SIZE = 2'd1;

    // One stored message identity
    typedef struct packed {
        logic [SEQ_W-1:0]  seqno;
        logic [HALF_W-1:0] addr_high;
        logic [HALF_W-1:0] addr_low;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

// ===== design/rmd_slot_ram.sv =====
// ----------------------------------------------------------------------------
// rmd_slot_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmd_slot_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/recent_message_dedup_ring_core.sv =====
// ----------------------------------------------------------------------------
// recent_message_dedup_ring_core
// Ring of recent message identities with add and duplicate check.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge with start high and busy low; its one
// result shows on o_valid for exactly one cycle and must be taken then, as
// the block cannot be stalled. An add, or a check with an empty list, leaves
// busy low, so another item may follow at once. A check scans the held
// entries newest first, one slot memory read per cycle, and keeps busy high
// until the match or, when nothing matches, the last held entry; the slot
// memory read is registered. Configuration is written only while busy is
// low and no result is pending: the user is bound to this, the block itself
// does not enforce it. A list_size write empties the list at once.
`timescale 1ns / 1ps
`include "recent_message_dedup_ring_core_macros.svh"

module recent_message_dedup_ring_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [rmd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Item input
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [rmd_pkg::SEQ_W-1:0]     i_message_seqno,
    input  logic [rmd_pkg::HALF_W-1:0]    i_originator_high,
    input  logic [rmd_pkg::HALF_W-1:0]    i_originator_low,
    // Result output
    output logic                          o_valid,
    output logic                          o_found,
    output logic [rmd_pkg::CNT_W-1:0]     o_entries_held
);

    import rmd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;

    // Configuration and ring control
    logic              r_mode;
    logic [CNT_W-1:0]  r_size;
    logic [ADDR_W-1:0] r_newest;
    logic [CNT_W-1:0]  r_held;

    // Scan control
    logic [ADDR_W-1:0] r_idx;
    logic [CNT_W-1:0]  r_left;
    logic              r_dv;

    // Search key, held during a scan
    logic [SEQ_W-1:0]  r_key_seq;
    logic [HALF_W-1:0] r_key_high;
    logic [HALF_W-1:0] r_key_low;

    // Result registers
    logic              r_out_valid;
    logic              r_out_found;
    logic [CNT_W-1:0]  r_out_held;

    logic              accept;
    logic              add_go;
    logic              chk_go;
    logic [ADDR_W-1:0] add_slot;
    logic [ADDR_W-1:0] idx_next;
    logic [CNT_W-1:0]  cfg_size;
    t_slot             wr_slot;
    t_slot             rd_slot;
    logic [SLOT_W-1:0] rd_bits;
    logic              rd_en;
    logic              hit;
    logic              scan_miss;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign add_go = accept && (i_func == FUNC_ADD);
    assign chk_go = accept && (i_func == FUNC_CHECK);

    // Slot below the newest, wrapping at the list size
    assign add_slot = (r_newest == '0) ? ADDR_W'(r_size - CNT_W'(1))
                                       : r_newest - ADDR_W'(1);

    // Next scan slot, one up, wrapping at the list size
    assign idx_next = ((CNT_W'(r_idx) + CNT_W'(1)) == r_size) ? '0
                                                              : r_idx + ADDR_W'(1);

    // Clip a written list size into one to the ring depth
    assign cfg_size = (i_cfg_data == '0) ? CNT_W'(1)
                    : (CNT_W'(i_cfg_data) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                    : CNT_W'(i_cfg_data);

    // Build the stored identity; IPv4 keeps only the low 32 bits
    always_comb begin
        wr_slot.seqno = i_message_seqno;
        if (r_mode) begin
            wr_slot.addr_high = i_originator_high;
            wr_slot.addr_low  = i_originator_low;
        end else begin
            wr_slot.addr_high = '0;
            wr_slot.addr_low  = {{(HALF_W-V4_W){1'b0}}, i_originator_low[V4_W-1:0]};
        end
    end

    assign rd_en = (r_state == ST_SCAN) && (r_left != '0);

    rmd_slot_ram #(
        .DATA_W (SLOT_W),
        .ADDR_W (ADDR_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (add_go),
        .i_waddr (add_slot),
        .i_wdata (wr_slot),
        .i_re    (rd_en),
        .i_raddr (r_idx),
        .o_rdata (rd_bits)
    );

    assign rd_slot = t_slot'(rd_bits);

    // Compare the slot read back against the key
    always_comb begin
        if (r_mode) begin
            hit = (rd_slot.seqno == r_key_seq) && (rd_slot.addr_high == r_key_high)
                  && (rd_slot.addr_low == r_key_low);
        end else begin
            hit = (rd_slot.seqno == r_key_seq)
                  && (rd_slot.addr_low[V4_W-1:0] == r_key_low[V4_W-1:0]);
        end
    end

    assign scan_miss = r_dv && !hit && (r_left == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (chk_go && (r_held != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((r_dv && hit) || scan_miss) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= 1'b0;
            r_size      <= CNT_W'(DEPTH);
            r_newest    <= '0;
            r_held      <= '0;
            r_left      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;

            // Apply configuration writes
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ADDR_MODE) begin
                    r_mode <= i_cfg_data[0];
                end else if (i_cfg_idx == REG_LIST_SIZE) begin
                    r_size   <= cfg_size;
                    r_newest <= '0;
                    r_held   <= '0;
                end
            end

            // Advance the ring on an add
            if (add_go) begin
                r_newest    <= add_slot;
                r_out_valid <= 1'b1;
                if (r_held < r_size) begin
                    r_held <= r_held + CNT_W'(1);
                end
            end

            // Start a scan, or answer at once when the list is empty
            if (chk_go) begin
                r_left <= r_held;
                if (r_held == '0) begin
                    r_out_valid <= 1'b1;
                end
            end

            // Step the scan and retire on a hit or on the last entry
            if (r_state == ST_SCAN) begin
                r_dv <= rd_en;
                if (rd_en) begin
                    r_left <= r_left - CNT_W'(1);
                end
                if ((r_dv && hit) || scan_miss) begin
                    r_dv        <= 1'b0;
                    r_left      <= '0;
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key_seq  <= i_message_seqno;
            r_key_high <= i_originator_high;
            r_key_low  <= i_originator_low;
            r_idx      <= r_newest;
        end else if (rd_en) begin
            r_idx <= idx_next;
        end

        if (add_go) begin
            r_out_found <= 1'b0;
            r_out_held  <= (r_held < r_size) ? r_held + CNT_W'(1) : r_held;
        end else if (chk_go) begin
            r_out_found <= 1'b0;
            r_out_held  <= r_held;
        end else if (r_state == ST_SCAN) begin
            r_out_found <= r_dv && hit;
            r_out_held  <= r_held;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_found        = r_out_found && r_out_valid;
    assign o_entries_held = r_out_held;

    // Ring invariants and result timing
    `RMD_ASSERT(a_held_le_size, r_held <= r_size, "held count exceeds list size")
    `RMD_ASSERT(a_newest_in_ring, CNT_W'(r_newest) < r_size, "newest slot outside the ring")
    `RMD_ASSERT(a_add_result, add_go |=> (o_valid && !o_found),
        "add gave no result in the next cycle")
    `RMD_ASSERT(a_left_le_held, r_left <= r_held, "scan runs past the held entries")
    `RMD_ASSERT(a_scan_ends_idle, (busy && o_valid) |-> 1'b0,
        "result shown while a scan is still running")

endmodule
